// File: design/rwsch_pkg.sv
// rwsch_pkg: shared types and constants for the retransmit window scheduler
// depends on nothing; imported by every other design file
`default_nettype none

package rwsch_pkg;

  localparam int WINDOW   = 64;
  localparam int SEQ_BITS = 32;
  localparam int CNT_W    = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_NACK = 2'd2,
    CMD_FIN  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_PENDING = 2'd0,
    SRC_NEW     = 2'd1,
    SRC_ROTATE  = 2'd2
  } src_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_e;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // per cell controls
  typedef struct packed {
    logic capture;
    logic shift;
    logic load;
  } cell_ctrl_t;

  // per row controls
  typedef struct packed {
    logic capture;
    logic remove_hit;
    logic pop;
    logic push;
  } row_ctrl_t;

  typedef struct packed {
    logic  send_valid;
    seq_t  send_seq;
    src_e  send_source;
    logic  took_new;
    logic  matched;
    logic  finished;
    logic  window_full;
  } res_t;

endpackage

`default_nettype wire

// File: design/rwsch_if.sv
// rwsch_req_if and rwsch_res_if: valid/ready channels of the scheduler
// depends on rwsch_pkg
`default_nettype none

interface rwsch_req_if import rwsch_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SEQ_BITS-1:0] seq;
  logic                new_valid;

  modport source (output valid, command, seq, new_valid, input ready);
  modport sink   (input valid, command, seq, new_valid, output ready);
endinterface

interface rwsch_res_if import rwsch_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                send_valid;
  logic [SEQ_BITS-1:0] send_seq;
  logic [1:0]          send_source;
  logic                took_new;
  logic                matched;
  logic                finished;
  logic                window_full;

  modport source (output valid, send_valid, send_seq, send_source, took_new, matched,
                  finished, window_full, input ready);
  modport sink   (input valid, send_valid, send_seq, send_source, took_new, matched,
                  finished, window_full, output ready);
endinterface

`default_nettype wire

// File: design/rwsch_cell.sv
// rwsch_cell: one queue slot holding a sequence number and a registered compare hit
// depends on rwsch_pkg
`default_nettype none

module rwsch_cell import rwsch_pkg::*; (
  input  wire  clk_i,
  input  cell_ctrl_t ctrl_i,
  input  seq_t key_i,
  input  seq_t shift_val_i,
  input  seq_t load_val_i,
  output seq_t val_o,
  output logic hit_o
);

  seq_t val_q;
  logic hit_q;

  // load wins over shift: the tail slot of a rotate takes the new value
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q <= load_val_i;
    end else if (ctrl_i.shift) begin
      val_q <= shift_val_i;
    end
    if (ctrl_i.capture) begin
      hit_q <= (val_q == key_i);
    end
  end

  assign val_o = val_q;
  assign hit_o = hit_q;

endmodule

`default_nettype wire

// File: design/rwsch_row.sv
// rwsch_row: ordered row of WINDOW cells with fill count, head pop, first-hit removal, tail push
// depends on rwsch_pkg and rwsch_cell
`default_nettype none

module rwsch_row import rwsch_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  row_ctrl_t ctrl_i,
  input  seq_t      key_i,
  input  seq_t      push_val_i,
  output cnt_t      count_o,
  output seq_t      head_o,
  output logic      found_o
);

  cnt_t              count_q, count_d;
  cnt_t              cnt_rm;
  seq_t              vals [WINDOW];
  logic [WINDOW-1:0] hit_raw;
  logic [WINDOW-1:0] hit_m;
  logic [WINDOW-1:0] pre;
  cell_ctrl_t        cctl [WINDOW];
  logic              dec;
  logic              do_push;

  // hits only count inside the filled part
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      hit_m[i] = hit_raw[i] && (cnt_t'(i) < count_q);
    end
  end

  // inclusive prefix or: cells at and after the first hit shift down
  always_comb begin
    pre = hit_m;
    for (int d = 1; d < WINDOW; d = d * 2) begin
      pre = pre | (pre << d);
    end
  end

  assign found_o = |hit_m;

  always_comb begin
    dec     = (ctrl_i.pop && (count_q != '0)) || (ctrl_i.remove_hit && found_o);
    cnt_rm  = count_q - cnt_t'(dec);
    do_push = ctrl_i.push && (cnt_rm < cnt_t'(WINDOW));
    count_d = cnt_rm + cnt_t'(do_push);
    for (int i = 0; i < WINDOW; i++) begin
      cctl[i].capture = ctrl_i.capture;
      cctl[i].shift   = ctrl_i.pop || (ctrl_i.remove_hit && pre[i]);
      cctl[i].load    = do_push && (cnt_rm == cnt_t'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    seq_t nb;
    if (g == WINDOW - 1) begin : g_last
      assign nb = push_val_i;
    end else begin : g_mid
      assign nb = vals[g+1];
    end
    rwsch_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cctl[g]),
      .key_i      (key_i),
      .shift_val_i(nb),
      .load_val_i (push_val_i),
      .val_o      (vals[g]),
      .hit_o      (hit_raw[g])
    );
  end

  assign count_o = count_q;
  assign head_o  = vals[0];

endmodule

`default_nettype wire

// File: design/retransmit_window_scheduler.sv
// retransmit_window_scheduler: top level, command sequencing and result register
// depends on rwsch_pkg, rwsch_if and rwsch_row
//
// usage
//   req_i carries one command per transfer: send request, ack, nack or fin, with a
//   sequence number and a flag for a fresh number offered by the source. res_o
//   returns exactly one result per command: the number chosen for transmission and
//   where it came from, whether the offered number was taken, whether an ack or
//   nack found its entry, the finished flag and a window full flag.
// structure
//   two rows of cells: the in-flight list (ordered, removable anywhere) and the
//   pending fifo. every in-flight cell compares its number with the command's
//   number on the accepting edge; the update step then shifts, pops and pushes.
// command flow
//   a command passes the compare in the in-flight cells and then the update
//   step, which also loads the result register. the result is visible the
//   cycle after the update. a new command is accepted only once the update
//   step of the last one is done, set by the compare-then-shift sequence.
// stall
//   the result register holds while res_o.ready is low; one more command can be
//   accepted and then waits in the update step until the register frees.
// reset
//   both lists empty, finished flag clear; no clearing pass, the cells hold
//   whatever they power up with until written.
`default_nettype none

module retransmit_window_scheduler import rwsch_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  rwsch_req_if.sink   req_i,
  rwsch_res_if.source res_o
);

  state_e    state_q, state_d;
  cmd_e      cmd_q;
  seq_t      seq_q;
  logic      new_q;
  logic      fin_q, fin_d;
  logic      out_valid_q, out_valid_d;
  res_t      out_q, out_d;

  row_ctrl_t fl_ctrl, pd_ctrl;
  seq_t      fl_push, pd_push;
  cnt_t      fl_cnt, pd_cnt;
  seq_t      fl_head, pd_head;
  logic      fl_found;
  logic [CNT_W:0] total;

  logic      req_fire;
  logic      can_go;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign can_go      = !out_valid_q || res_o.ready;
  assign total       = {1'b0, fl_cnt} + {1'b0, pd_cnt};

  // command capture on the accepting edge
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= cmd_e'(req_i.command);
      seq_q <= req_i.seq;
      new_q <= req_i.new_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    fl_ctrl     = '0;
    pd_ctrl     = '0;
    fl_push     = seq_q;
    pd_push     = seq_q;

    // in-flight cells compare against the incoming number as it is accepted
    fl_ctrl.capture = req_fire;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (can_go) begin
          state_d           = ST_IDLE;
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.send_source = SRC_PENDING;
          case (cmd_q)
            CMD_SEND: begin
              if (!fin_q) begin
                if (pd_cnt != '0) begin
                  // pending head goes out first
                  out_d.send_valid = 1'b1;
                  out_d.send_seq   = pd_head;
                  pd_ctrl.pop      = 1'b1;
                  fl_ctrl.push     = 1'b1;
                  fl_push          = pd_head;
                end else if (new_q && (total < (CNT_W+1)'(WINDOW))) begin
                  out_d.send_valid  = 1'b1;
                  out_d.send_seq    = seq_q;
                  out_d.send_source = SRC_NEW;
                  out_d.took_new    = 1'b1;
                  fl_ctrl.push      = 1'b1;
                end else begin
                  // window full or nothing offered: rotate the oldest entry
                  out_d.window_full = new_q;
                  if (fl_cnt != '0) begin
                    out_d.send_valid  = 1'b1;
                    out_d.send_seq    = fl_head;
                    out_d.send_source = SRC_ROTATE;
                    fl_ctrl.pop       = 1'b1;
                    fl_ctrl.push      = 1'b1;
                    fl_push           = fl_head;
                  end
                end
              end
            end
            CMD_ACK: begin
              fl_ctrl.remove_hit = 1'b1;
              out_d.matched      = fl_found;
            end
            CMD_NACK: begin
              // the removed entry equals the key, so the key goes to pending
              fl_ctrl.remove_hit = 1'b1;
              pd_ctrl.push       = fl_found;
              out_d.matched      = fl_found;
            end
            CMD_FIN: begin
              fin_d = 1'b1;
            end
            default: begin
            end
          endcase
          out_d.finished = fin_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  rwsch_row u_flight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fl_ctrl),
    .key_i     (req_i.seq),
    .push_val_i(fl_push),
    .count_o   (fl_cnt),
    .head_o    (fl_head),
    .found_o   (fl_found)
  );

  // pending fifo never searches, its compare key is unused
  rwsch_row u_pending (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pd_ctrl),
    .key_i     (seq_q),
    .push_val_i(pd_push),
    .count_o   (pd_cnt),
    .head_o    (pd_head),
    .found_o   ()
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.send_valid  = out_q.send_valid;
  assign res_o.send_seq    = out_q.send_seq;
  assign res_o.send_source = out_q.send_source;
  assign res_o.took_new    = out_q.took_new;
  assign res_o.matched     = out_q.matched;
  assign res_o.finished    = out_q.finished;
  assign res_o.window_full = out_q.window_full;

  // both lists together never exceed the window
  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CNT_W+1)'(WINDOW))
    else $error("pending plus in-flight exceeds window");

  // a taken new number is always the one sent
  a_took_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.took_new |-> out_q.send_valid && (out_q.send_source == SRC_NEW))
    else $error("took_new without a new send");

  // a blocked update step waits for the result register
  a_apply_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) && out_valid_q && !res_o.ready |=> (state_q == ST_APPLY))
    else $error("update step ran over a held result");

endmodule

`default_nettype wire
